@@ rtl/wsfr_pkg.sv @@
// Shared types and constants for the WebSocket frame receiver.
`default_nettype none

package wsfr_pkg;

  localparam int unsigned LenW = 21;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_MSG_DONE  = 3'd1,
    EV_PING_DONE = 3'd2,
    EV_PONG_SEEN = 3'd3,
    EV_CLOSE     = 3'd4,
    EV_TOO_LONG  = 3'd5,
    EV_NO_BUFFER = 3'd6,
    EV_MALFORMED = 3'd7
  } evt_e;

  localparam logic [3:0]      OPC_CLOSE      = 4'h8;
  localparam logic [3:0]      OPC_PING       = 4'h9;
  localparam logic [3:0]      OPC_PONG       = 4'hA;
  localparam logic [6:0]      LEN7_EXT16     = 7'd126;
  localparam logic [6:0]      LEN7_EXT64     = 7'd127;
  localparam logic [LenW-1:0] CTRL_MAX_LEN   = 21'd125;
  localparam logic [15:0]     CLOSE_NORMAL   = 16'd1000;
  localparam logic [15:0]     CLOSE_PROTOCOL = 16'd1002;
  localparam logic [LenW-1:0] MAX_FRAME_RST  = 21'd1048576;
  localparam logic [LenW-1:0] MSG_CAP_RST    = 21'd4096;

  localparam logic CFG_MAX_FRAME = 1'b0;
  localparam logic CFG_MSG_CAP   = 1'b1;

  typedef struct packed {
    logic [LenW-1:0] max_frame_length;
    logic [LenW-1:0] message_capacity;
  } cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        payload_is_control;
    logic [3:0]  message_opcode;
    evt_e        event_res;
    logic [15:0] close_status;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/wsfr_cfg.sv @@
// Configuration registers: frame length limit and message capacity.
`default_nettype none

module wsfr_cfg (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic                     cfg_index_i,
  input  wire logic [wsfr_pkg::LenW-1:0] cfg_data_i,
  output wsfr_pkg::cfg_t                cfg_o
);

  wsfr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wsfr_pkg::CFG_MAX_FRAME: cfg_d.max_frame_length = cfg_data_i;
        wsfr_pkg::CFG_MSG_CAP:   cfg_d.message_capacity = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_frame_length <= wsfr_pkg::MAX_FRAME_RST;
      cfg_q.message_capacity <= wsfr_pkg::MSG_CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ rtl/wsfr_in_reg.sv @@
// Input register stage holding one received request.
`default_nettype none

module wsfr_in_reg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic       mode_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output wsfr_pkg::item_t item_o
);

  logic            valid_q, valid_d;
  wsfr_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) valid_d = 1'b0;
    if (valid_i && ready_o) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q.mode      <= mode_i;
      item_q.data_byte <= data_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

@@ rtl/wsfr_parser.sv @@
// Frame header parser, payload unmasking and message bookkeeping.
`default_nettype none

module wsfr_parser (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wsfr_pkg::item_t item_i,
  input  wsfr_pkg::cfg_t  cfg_i,
  output wsfr_pkg::res_t  res_o
);

  localparam int unsigned LW = wsfr_pkg::LenW;

  logic [3:0]    hc_q, hc_d;
  logic [4:0]    fo_q, fo_d;
  logic [7:0]    ml_q, ml_d;
  logic [63:0]   ext_q, ext_d;
  logic [31:0]   key_q, key_d;
  logic [LW-1:0] fr_q, fr_d;
  logic [LW-1:0] mu_q, mu_d;
  logic [3:0]    mop_q, mop_d;
  logic [15:0]   cfb_q, cfb_d;
  logic          halted_q, halted_d;

  function automatic logic [3:0] ext_bytes(input logic [7:0] ml);
    logic [3:0] n;
    n = 4'd0;
    if (ml[6:0] == wsfr_pkg::LEN7_EXT16) n = 4'd2;
    else if (ml[6:0] == wsfr_pkg::LEN7_EXT64) n = 4'd8;
    return n;
  endfunction

  function automatic logic [3:0] header_need(input logic [7:0] ml);
    return 4'd2 + ext_bytes(ml) + (ml[7] ? 4'd4 : 4'd0);
  endfunction

  function automatic logic [63:0] frame_len(input logic [7:0] ml, input logic [63:0] ext);
    logic [63:0] l;
    l = {57'd0, ml[6:0]};
    if (ml[6:0] == wsfr_pkg::LEN7_EXT16) l = {48'd0, ext[15:0]};
    else if (ml[6:0] == wsfr_pkg::LEN7_EXT64) l = ext;
    return l;
  endfunction

  logic          in_hdr;
  logic [63:0]   cur_len;

  assign in_hdr  = (hc_q < 4'd2) || (hc_q < header_need(ml_q));
  assign cur_len = frame_len(ml_q, ext_q);

  always_comb begin
    logic [7:0]    b;
    logic [7:0]    kb;
    logic [63:0]   len64;
    logic [LW-1:0] fin_len;
    logic          do_finish;
    logic          do_advance;
    logic          too_long;

    hc_d = hc_q;   fo_d = fo_q;   ml_d = ml_q;   ext_d = ext_q;  key_d = key_q;
    fr_d = fr_q;   mu_d = mu_q;   mop_d = mop_q; cfb_d = cfb_q;  halted_d = halted_q;
    res_o      = '0;
    b          = item_i.data_byte;
    kb         = 8'd0;
    len64      = 64'd0;
    fin_len    = '0;
    do_finish  = 1'b0;
    do_advance = 1'b0;
    too_long   = 1'b0;

    if (step_i) begin
      if (item_i.mode) begin
        hc_d = '0;  fo_d = '0;  ml_d = '0;  ext_d = '0;  key_d = '0;
        fr_d = '0;  mu_d = '0;  mop_d = '0; cfb_d = '0;  halted_d = 1'b0;
      end else if (!halted_q) begin
        if (in_hdr) begin
          if (hc_q == 4'd0) fo_d = {b[7], b[3:0]};
          else if (hc_q == 4'd1) ml_d = b;
          else if (hc_q < 4'd2 + ext_bytes(ml_q)) ext_d = {ext_q[55:0], b};
          else key_d = {key_q[23:0], b};
          hc_d = hc_q + 4'd1;
          // The last header byte decides on the frame as a whole.
          if (!((hc_d < 4'd2) || (hc_d < header_need(ml_d)))) begin
            len64    = frame_len(ml_d, ext_d);
            too_long = (|len64[63:LW]) || (len64[LW-1:0] > cfg_i.max_frame_length);
            if (too_long) begin
              res_o.event_res = wsfr_pkg::EV_TOO_LONG;
              halted_d        = 1'b1;
            end else if (fo_d[3] && (!fo_d[4] || len64[LW-1:0] > wsfr_pkg::CTRL_MAX_LEN)) begin
              res_o.event_res = wsfr_pkg::EV_MALFORMED;
              halted_d        = 1'b1;
            end else begin
              if (!fo_d[3] && fo_d[3:0] != 4'd0) mop_d = fo_d[3:0];
              fr_d = '0;
              if (len64[LW-1:0] == '0) do_finish = 1'b1;
            end
          end
        end else begin
          case (fr_q[1:0])
            2'd0:    kb = key_q[31:24];
            2'd1:    kb = key_q[23:16];
            2'd2:    kb = key_q[15:8];
            default: kb = key_q[7:0];
          endcase
          if (ml_q[7]) b = b ^ kb;
          if (fo_q[3]) begin
            // Pong payload is swallowed; other control bytes go out.
            if (fo_q[3:0] != wsfr_pkg::OPC_PONG) begin
              res_o.payload_byte       = b;
              res_o.payload_valid      = 1'b1;
              res_o.payload_is_control = 1'b1;
              res_o.message_opcode     = fo_q[3:0];
            end
            if (fr_q == '0) cfb_d[15:8] = b;
            else if (fr_q == LW'(1)) cfb_d[7:0] = b;
            do_advance = 1'b1;
          end else if (mu_q >= cfg_i.message_capacity) begin
            res_o.event_res = wsfr_pkg::EV_NO_BUFFER;
            halted_d        = 1'b1;
          end else begin
            mu_d                 = mu_q + LW'(1);
            res_o.payload_byte   = b;
            res_o.payload_valid  = 1'b1;
            res_o.message_opcode = mop_q;
            do_advance           = 1'b1;
          end
          if (do_advance) begin
            fr_d = fr_q + LW'(1);
            if (fr_d >= cur_len[LW-1:0]) do_finish = 1'b1;
          end
        end

        if (do_finish) begin
          fin_len = fr_d;
          hc_d    = 4'd0;
          fr_d    = '0;
          if (fo_d[3]) begin
            res_o.message_opcode = fo_d[3:0];
            if (fo_d[3:0] == wsfr_pkg::OPC_PING) begin
              res_o.event_res = wsfr_pkg::EV_PING_DONE;
            end else if (fo_d[3:0] == wsfr_pkg::OPC_PONG) begin
              res_o.event_res = wsfr_pkg::EV_PONG_SEEN;
            end else if (fo_d[3:0] == wsfr_pkg::OPC_CLOSE) begin
              res_o.event_res    = wsfr_pkg::EV_CLOSE;
              res_o.close_status = (fin_len > LW'(2) && cfb_d != 16'd0) ?
                                   cfb_d : wsfr_pkg::CLOSE_NORMAL;
              halted_d           = 1'b1;
            end else begin
              res_o.event_res    = wsfr_pkg::EV_CLOSE;
              res_o.close_status = wsfr_pkg::CLOSE_PROTOCOL;
              halted_d           = 1'b1;
            end
            cfb_d = '0;
          end else if (fo_d[4]) begin
            res_o.message_opcode = mop_d;
            res_o.event_res      = wsfr_pkg::EV_MSG_DONE;
            mu_d                 = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q     <= '0;
      fo_q     <= '0;
      ml_q     <= '0;
      ext_q    <= '0;
      key_q    <= '0;
      fr_q     <= '0;
      mu_q     <= '0;
      mop_q    <= '0;
      cfb_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      hc_q     <= hc_d;
      fo_q     <= fo_d;
      ml_q     <= ml_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      fr_q     <= fr_d;
      mu_q     <= mu_d;
      mop_q    <= mop_d;
      cfb_q    <= cfb_d;
      halted_q <= halted_d;
    end
  end

`ifndef ASSERT_OFF
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.mode |=> (hc_q == 4'd0) && !halted_q && (mu_q == '0) && (fr_q == '0))
    else $error("restart did not clear the parser");

  a_halt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.mode && halted_q |=> halted_q && $stable(hc_q) && $stable(fr_q))
    else $error("halted parser changed state");

  a_halting_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (res_o.event_res == wsfr_pkg::EV_TOO_LONG ||
               res_o.event_res == wsfr_pkg::EV_NO_BUFFER ||
               res_o.event_res == wsfr_pkg::EV_MALFORMED ||
               res_o.event_res == wsfr_pkg::EV_CLOSE) |=> halted_q)
    else $error("error or close event without halt");

  a_ctrl_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.payload_is_control |-> res_o.payload_valid && res_o.message_opcode[3])
    else $error("control byte tagged without a control opcode");

  a_payload_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !halted_q && !in_hdr |-> ({43'd0, fr_q} < cur_len))
    else $error("payload count reached the frame length outside the header");
`endif

endmodule

`default_nettype wire

@@ rtl/wsfr_out_reg.sv @@
// Result register that holds a finished result until it is taken.
`default_nettype none

module wsfr_out_reg (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      load_i,
  input  wsfr_pkg::res_t res_i,
  output logic           free_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output wsfr_pkg::res_t res_o
);

  logic           valid_q, valid_d;
  wsfr_pkg::res_t res_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) valid_d = 1'b0;
    if (load_i) valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

@@ rtl/websocket_frame_receiver_core.sv @@
// Top level of the WebSocket frame receiver: one result per received byte.
//
//  Channel  | Direction | Handshake             | Payload
//  ---------+-----------+-----------------------+-------------------------------------
//  s_axis   | in        | tvalid / tready       | tdata: data_byte; tuser: mode
//  m_axis   | out       | tvalid / tready       | tdata: byte,valid,opcode,event,status
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index_i, cfg_data_i (21 bits)
//
// A byte's result is loaded into the result register when the parser takes the byte:
// the input register holds it while the parser logic works on it. One byte is
// accepted every cycle while the result register is free. The result register
// stalls the parser; the input register then fills and s_axis_tready drops.
// The config port is always ready. Reset clears all parser state and loads the default limits.
`default_nettype none

module websocket_frame_receiver_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tuser,   // [0] mode
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] payload_byte, [8] payload_valid,
                                           // [12:9] message_opcode, [15:13] event_res,
                                           // [31:16] close_status
  output logic             m_axis_tuser,   // [0] payload_is_control
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [20:0] cfg_data_i
);

  wsfr_pkg::cfg_t  cfg;
  wsfr_pkg::item_t item;
  wsfr_pkg::res_t  res_next;
  wsfr_pkg::res_t  res_out;
  logic            item_valid;
  logic            out_free;
  logic            step;

  assign step = item_valid && out_free;

  wsfr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  wsfr_in_reg u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .mode_i      (s_axis_tuser),
    .data_byte_i (s_axis_tdata),
    .take_i      (step),
    .valid_o     (item_valid),
    .item_o      (item)
  );

  wsfr_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .cfg_i  (cfg),
    .res_o  (res_next)
  );

  wsfr_out_reg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (step),
    .res_i   (res_next),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = {res_out.close_status, res_out.event_res, res_out.message_opcode,
                         res_out.payload_valid, res_out.payload_byte};
  assign m_axis_tuser = res_out.payload_is_control;

endmodule

`default_nettype wire
